>>> src/luf_pkg.sv
// Shared types and constants for the LU factor and solve block.
// Depends on nothing; imported by every module of the block but luf_ram.
`timescale 1ns / 1ps

package luf_pkg;

    typedef enum logic [1:0] {
        FN_LOAD_MAT = 2'd0,
        FN_FACTOR   = 2'd1,
        FN_LOAD_RHS = 2'd2,
        FN_SOLVE    = 2'd3
    } t_func;

    typedef enum logic [0:0] {
        CFG_ORDER     = 1'b0,
        CFG_TRANSPOSE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_func              func;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [5:0]         index;
        logic signed [31:0] result_value;
        logic [6:0]         info;
        logic               status;
        logic               last;
    } t_out_word;

    typedef enum logic [1:0] {
        ALU_MUL = 2'd0,
        ALU_SUB = 2'd1,
        ALU_DIV = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic               start;
        t_alu_op            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [31:0] res;
    } t_alu_rsp;

    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [63:0] Q_HALF = 64'sd32768;
    localparam int unsigned        FRAC   = 16;
    localparam int unsigned        DIV_STEPS = 48;

endpackage

>>> src/luf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module luf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/luf_alu.sv
// Shared Q16.16 arithmetic unit: rounded multiply, saturating subtract,
// bit-serial divide. Depends on luf_pkg.
`timescale 1ns / 1ps

module luf_alu
    import luf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    typedef enum logic [3:0] {
        AS_IDLE = 4'b0001,
        AS_MUL  = 4'b0010,
        AS_DIV  = 4'b0100,
        AS_FIN  = 4'b1000
    } t_alu_st;

    t_alu_st            r_state;
    logic               r_done;
    logic               r_sat;
    logic signed [31:0] r_res;
    logic signed [63:0] r_prod;
    logic [47:0]        r_num;
    logic [47:0]        r_quo;
    logic [31:0]        r_rem;
    logic [31:0]        r_dvs;
    logic               r_neg;
    logic [5:0]         r_cnt;

    logic [31:0]        a_mag;
    logic [31:0]        b_mag;
    logic signed [32:0] sub_d;
    logic signed [63:0] rnd_t;
    logic signed [63:0] rnd_q;
    logic [32:0]        rem_sh;
    logic [32:0]        rem_df;
    logic               rem_ge;

    always_comb begin
        a_mag  = i_req.a[31] ? (~i_req.a + 32'd1) : i_req.a;
        b_mag  = i_req.b[31] ? (~i_req.b + 32'd1) : i_req.b;
        sub_d  = {i_req.a[31], i_req.a} - {i_req.b[31], i_req.b};
        rnd_t  = r_prod + Q_HALF;
        rnd_q  = rnd_t >>> FRAC;
        rem_sh = {r_rem, r_num[47]};
        rem_df = rem_sh - {1'b0, r_dvs};
        rem_ge = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                AS_IDLE: begin
                    if (i_req.start) begin
                        case (i_req.op)
                            ALU_MUL: r_state <= AS_MUL;
                            ALU_DIV: begin
                                if (i_req.b == '0) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_state <= AS_DIV;
                                end
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                AS_MUL: begin
                    r_done  <= 1'b1;
                    r_state <= AS_IDLE;
                end
                AS_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= AS_FIN;
                    end
                end
                AS_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= AS_IDLE;
                end
                default: r_state <= AS_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            AS_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        ALU_MUL: r_prod <= i_req.a * i_req.b;
                        ALU_DIV: begin
                            if (i_req.b == '0) begin
                                r_res <= i_req.a[31] ? Q_MIN : Q_MAX;
                                r_sat <= 1'b1;
                            end else begin
                                r_num <= {a_mag, 16'd0};
                                r_rem <= '0;
                                r_quo <= '0;
                                r_dvs <= b_mag;
                                r_neg <= i_req.a[31] ^ i_req.b[31];
                                r_cnt <= 6'(DIV_STEPS - 1);
                            end
                        end
                        default: begin
                            if (sub_d[32] != sub_d[31]) begin
                                r_res <= sub_d[32] ? Q_MIN : Q_MAX;
                                r_sat <= 1'b1;
                            end else begin
                                r_res <= sub_d[31:0];
                                r_sat <= 1'b0;
                            end
                        end
                    endcase
                end
            end
            AS_MUL: begin
                if (rnd_q > 64'(Q_MAX)) begin
                    r_res <= Q_MAX;
                    r_sat <= 1'b1;
                end else if (rnd_q < 64'(Q_MIN)) begin
                    r_res <= Q_MIN;
                    r_sat <= 1'b1;
                end else begin
                    r_res <= rnd_q[31:0];
                    r_sat <= 1'b0;
                end
            end
            AS_DIV: begin
                r_rem <= rem_ge ? rem_df[31:0] : rem_sh[31:0];
                r_quo <= {r_quo[46:0], rem_ge};
                r_num <= {r_num[46:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end
            AS_FIN: begin
                if (!r_neg) begin
                    r_sat <= (r_quo > 48'h0000_7FFF_FFFF);
                    r_res <= (r_quo > 48'h0000_7FFF_FFFF) ? Q_MAX : r_quo[31:0];
                end else begin
                    r_sat <= (r_quo > 48'h0000_8000_0000);
                    r_res <= (r_quo > 48'h0000_8000_0000) ? Q_MIN
                                                         : (~r_quo[31:0] + 32'd1);
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.res  = r_res;

endmodule

>>> src/lu_factor_and_solve.sv
// Top level: LU factorization with partial pivoting and solve, Q16.16.
// Depends on luf_pkg, luf_ram, luf_alu.
`timescale 1ns / 1ps
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_word  (t_in_word)
//  out     | output    | o_out_valid/ i_out_ready| o_out_word (t_out_word)
//  cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
//  Loads are accepted back to back while the output register drains. Factor
//  and solve are paced by the single shared multiply/subtract/divide unit
//  (a divide makes one quotient bit per cycle). Solve ends by emitting one
//  word per solution element, through a read state and a write state.
//  The input stays not ready during both. Reset is synchronous, active low;
//  it resets the sequencer, the output valid, the config registers (order
//  to 16, transpose off) and the singular info. Stores are not cleared.
//  A stalled output holds the sequencer at the point where it emits.

module lu_factor_and_solve
    import luf_pkg::*;
#(
    parameter int MAX_ORDER = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_cfg_reg   i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_ORDER);
    localparam int CW = $clog2(MAX_ORDER + 1);
    localparam int MD = 1 << (2 * IW);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    typedef enum logic [35:0] {
        ST_IDLE     = 36'b1 << 0,
        ST_F_INIT   = 36'b1 << 1,
        ST_F_PS_RP  = 36'b1 << 2,
        ST_F_PS_RM  = 36'b1 << 3,
        ST_F_PS_CMP = 36'b1 << 4,
        ST_F_SW_R   = 36'b1 << 5,
        ST_F_SW_W1  = 36'b1 << 6,
        ST_F_SW_W2  = 36'b1 << 7,
        ST_F_D_RP   = 36'b1 << 8,
        ST_F_D_RM   = 36'b1 << 9,
        ST_F_D_DIV  = 36'b1 << 10,
        ST_F_D_W    = 36'b1 << 11,
        ST_F_U_RP   = 36'b1 << 12,
        ST_F_U_RL   = 36'b1 << 13,
        ST_F_U_RU   = 36'b1 << 14,
        ST_F_U_MUL  = 36'b1 << 15,
        ST_F_U_WM   = 36'b1 << 16,
        ST_F_U_WS   = 36'b1 << 17,
        ST_F_E_RP   = 36'b1 << 18,
        ST_F_E_RM   = 36'b1 << 19,
        ST_F_E_CHK  = 36'b1 << 20,
        ST_F_FIN    = 36'b1 << 21,
        ST_S_BEGIN  = 36'b1 << 22,
        ST_S_P      = 36'b1 << 23,
        ST_S_T      = 36'b1 << 24,
        ST_S_CHK    = 36'b1 << 25,
        ST_S_RP     = 36'b1 << 26,
        ST_S_RD     = 36'b1 << 27,
        ST_S_MUL    = 36'b1 << 28,
        ST_S_WM     = 36'b1 << 29,
        ST_S_WS     = 36'b1 << 30,
        ST_S_TAIL   = 36'b1 << 31,
        ST_S_DIV    = 36'b1 << 32,
        ST_S_DW     = 36'b1 << 33,
        ST_EM_R     = 36'b1 << 34,
        ST_EM_W     = 36'b1 << 35
    } t_state;

    // sequencer and datapath registers
    t_state             r_state, n_state;
    logic [CW-1:0]      r_k, n_k, r_i, n_i, r_j, n_j, r_mi, n_mi;
    logic [IW-1:0]      r_pk, n_pk, r_pi, n_pi, r_pm, n_pm;
    logic               r_found, n_found;
    logic [31:0]        r_best, n_best;
    logic signed [31:0] r_pv, n_pv, r_t, n_t, r_l, n_l;
    logic [6:0]         r_info, n_info, r_sing, n_sing;
    logic               r_sat, n_sat, r_back, n_back;
    logic [6:0]         r_order, n_order;
    logic               r_tmode, n_tmode;
    logic               r_ovalid, n_ovalid;
    t_out_word          r_out, n_out;

    // store ports
    logic               mat_we;
    logic [2*IW-1:0]    mat_waddr, mat_raddr;
    logic [31:0]        mat_wdata, mat_rdata;
    logic               piv_we;
    logic [IW-1:0]      piv_waddr, piv_raddr, piv_wdata, piv_rdata;
    logic               rhs_we;
    logic [IW-1:0]      rhs_waddr, rhs_raddr;
    logic [31:0]        rhs_wdata, rhs_rdata;
    logic               sol_we;
    logic [IW-1:0]      sol_waddr, sol_raddr;
    logic [31:0]        sol_wdata, sol_rdata;

    t_alu_req           alu_req;
    t_alu_rsp           alu_rsp;

    logic [CW-1:0]      n_eff, n_m1, k_inc, k_inc2, i_inc, j_inc;
    logic               in_acc, out_free;
    logic [31:0]        ps_mag;
    logic               ps_upd;
    logic               factor_next, solve_next;
    logic               need_div;

    luf_ram #(.WIDTH(32), .DEPTH(MD)) u_mat (
        .i_clk(i_clk), .i_we(mat_we), .i_waddr(mat_waddr), .i_wdata(mat_wdata),
        .i_raddr(mat_raddr), .o_rdata(mat_rdata)
    );
    luf_ram #(.WIDTH(IW), .DEPTH(MAX_ORDER)) u_piv (
        .i_clk(i_clk), .i_we(piv_we), .i_waddr(piv_waddr), .i_wdata(piv_wdata),
        .i_raddr(piv_raddr), .o_rdata(piv_rdata)
    );
    luf_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_rhs (
        .i_clk(i_clk), .i_we(rhs_we), .i_waddr(rhs_waddr), .i_wdata(rhs_wdata),
        .i_raddr(rhs_raddr), .o_rdata(rhs_rdata)
    );
    luf_ram #(.WIDTH(32), .DEPTH(MAX_ORDER)) u_sol (
        .i_clk(i_clk), .i_we(sol_we), .i_waddr(sol_waddr), .i_wdata(sol_wdata),
        .i_raddr(sol_raddr), .o_rdata(sol_rdata)
    );

    luf_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(alu_req), .o_rsp(alu_rsp)
    );

    // effective order: 0 acts as 1, above the built size clamps
    always_comb begin
        if (r_order == '0) begin
            n_eff = ONE_C;
        end else if (r_order > 7'(MAX_ORDER)) begin
            n_eff = CW'(MAX_ORDER);
        end else begin
            n_eff = r_order[CW-1:0];
        end
    end

    assign n_m1     = n_eff - ONE_C;
    assign k_inc    = r_k + ONE_C;
    assign k_inc2   = r_k + TWO_C;
    assign i_inc    = r_i + ONE_C;
    assign j_inc    = r_j + ONE_C;
    assign out_free = !r_ovalid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && out_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign ps_mag   = mat_rdata[31] ? (~mat_rdata + 32'd1) : mat_rdata;
    assign ps_upd   = ps_mag > r_best;
    // plain backward and transposed forward end in a divide by the diagonal
    assign need_div = r_tmode ^ r_back;

    always_comb begin
        n_state = r_state;
        n_k = r_k;   n_i = r_i;   n_j = r_j;   n_mi = r_mi;
        n_pk = r_pk; n_pi = r_pi; n_pm = r_pm;
        n_found = r_found; n_best = r_best; n_pv = r_pv;
        n_t = r_t;   n_l = r_l;
        n_info = r_info; n_sing = r_sing; n_sat = r_sat; n_back = r_back;
        n_order = r_order; n_tmode = r_tmode;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out = r_out;
        factor_next = 1'b0;
        solve_next  = 1'b0;

        mat_we = 1'b0; mat_waddr = '0; mat_wdata = '0; mat_raddr = '0;
        piv_we = 1'b0; piv_waddr = '0; piv_wdata = '0; piv_raddr = '0;
        rhs_we = 1'b0; rhs_waddr = '0; rhs_wdata = '0; rhs_raddr = '0;
        sol_we = 1'b0; sol_waddr = '0; sol_wdata = '0; sol_raddr = '0;

        alu_req.start = 1'b0;
        alu_req.op    = ALU_SUB;
        alu_req.a     = r_t;
        alu_req.b     = alu_rsp.res;

        if (alu_rsp.done && alu_rsp.sat) begin
            n_sat = 1'b1;
        end

        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ORDER) begin
                n_order = i_cfg_data;
            end else begin
                n_tmode = i_cfg_data[0];
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_word.func)
                        FN_LOAD_MAT: begin
                            mat_we    = ({1'b0, i_in_word.row} < 7'(MAX_ORDER)) &&
                                        ({1'b0, i_in_word.col} < 7'(MAX_ORDER));
                            mat_waddr = {i_in_word.row[IW-1:0], i_in_word.col[IW-1:0]};
                            mat_wdata = i_in_word.value;
                            n_ovalid  = 1'b1;
                            n_out     = '{index: '0, result_value: '0, info: r_sing,
                                          status: 1'b0, last: 1'b1};
                        end
                        FN_LOAD_RHS: begin
                            rhs_we    = ({1'b0, i_in_word.row} < 7'(MAX_ORDER));
                            rhs_waddr = i_in_word.row[IW-1:0];
                            rhs_wdata = i_in_word.value;
                            n_ovalid  = 1'b1;
                            n_out     = '{index: '0, result_value: '0, info: r_sing,
                                          status: 1'b0, last: 1'b1};
                        end
                        FN_FACTOR: begin
                            n_sat   = 1'b0;
                            n_info  = '0;
                            n_k     = '0;
                            n_state = ST_F_INIT;
                        end
                        default: begin
                            n_sat   = 1'b0;
                            n_k     = '0;
                            n_back  = 1'b0;
                            n_state = ST_S_BEGIN;
                        end
                    endcase
                end
            end

            // ---- factor ----
            ST_F_INIT: begin
                piv_we    = 1'b1;
                piv_waddr = r_k[IW-1:0];
                piv_wdata = r_k[IW-1:0];
                if (k_inc == n_eff) begin
                    n_k = '0;
                    if (n_eff > ONE_C) begin
                        n_i = '0; n_best = '0; n_found = 1'b0;
                        n_state = ST_F_PS_RP;
                    end else begin
                        n_state = ST_F_E_RP;
                    end
                end else begin
                    n_k = k_inc;
                end
            end
            ST_F_PS_RP: begin
                piv_raddr = r_i[IW-1:0];
                n_state   = ST_F_PS_RM;
            end
            ST_F_PS_RM: begin
                n_pi      = piv_rdata;
                mat_raddr = {piv_rdata, r_k[IW-1:0]};
                n_state   = ST_F_PS_CMP;
            end
            ST_F_PS_CMP: begin
                if (ps_upd) begin
                    n_best = ps_mag; n_found = 1'b1;
                    n_pm = r_pi; n_pv = mat_rdata; n_mi = r_i;
                end
                if (i_inc == n_eff) begin
                    if (!(r_found || ps_upd)) begin
                        // all-zero column: skip it
                        n_info = 7'(k_inc);
                        factor_next = 1'b1;
                    end else begin
                        n_state = ST_F_SW_R;
                    end
                end else begin
                    n_i = i_inc;
                    n_state = ST_F_PS_RP;
                end
            end
            ST_F_SW_R: begin
                piv_raddr = r_k[IW-1:0];
                n_state   = ST_F_SW_W1;
            end
            ST_F_SW_W1: begin
                piv_we    = 1'b1;
                piv_waddr = r_mi[IW-1:0];
                piv_wdata = piv_rdata;
                n_state   = ST_F_SW_W2;
            end
            ST_F_SW_W2: begin
                piv_we    = 1'b1;
                piv_waddr = r_k[IW-1:0];
                piv_wdata = r_pm;
                n_pk      = r_pm;
                n_i       = k_inc;
                n_state   = ST_F_D_RP;
            end
            ST_F_D_RP: begin
                piv_raddr = r_i[IW-1:0];
                n_state   = ST_F_D_RM;
            end
            ST_F_D_RM: begin
                n_pi      = piv_rdata;
                mat_raddr = {piv_rdata, r_k[IW-1:0]};
                n_state   = ST_F_D_DIV;
            end
            ST_F_D_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_req.a     = mat_rdata;
                alu_req.b     = r_pv;
                n_state       = ST_F_D_W;
            end
            ST_F_D_W: begin
                if (alu_rsp.done) begin
                    mat_we    = 1'b1;
                    mat_waddr = {r_pi, r_k[IW-1:0]};
                    mat_wdata = alu_rsp.res;
                    if (i_inc == n_eff) begin
                        n_i = k_inc; n_j = k_inc;
                        n_state = ST_F_U_RP;
                    end else begin
                        n_i = i_inc;
                        n_state = ST_F_D_RP;
                    end
                end
            end
            ST_F_U_RP: begin
                piv_raddr = r_i[IW-1:0];
                n_state   = ST_F_U_RL;
            end
            ST_F_U_RL: begin
                n_pi      = piv_rdata;
                mat_raddr = {piv_rdata, r_k[IW-1:0]};
                n_state   = ST_F_U_RU;
            end
            ST_F_U_RU: begin
                n_l       = mat_rdata;
                mat_raddr = {r_pk, r_j[IW-1:0]};
                n_state   = ST_F_U_MUL;
            end
            ST_F_U_MUL: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.a     = r_l;
                alu_req.b     = mat_rdata;
                mat_raddr     = {r_pi, r_j[IW-1:0]};
                n_state       = ST_F_U_WM;
            end
            ST_F_U_WM: begin
                mat_raddr = {r_pi, r_j[IW-1:0]};
                if (alu_rsp.done) begin
                    alu_req.start = 1'b1;
                    alu_req.a     = mat_rdata;
                    n_state       = ST_F_U_WS;
                end
            end
            ST_F_U_WS: begin
                if (alu_rsp.done) begin
                    mat_we    = 1'b1;
                    mat_waddr = {r_pi, r_j[IW-1:0]};
                    mat_wdata = alu_rsp.res;
                    if (i_inc < n_eff) begin
                        n_i = i_inc;
                        n_state = ST_F_U_RP;
                    end else if (j_inc < n_eff) begin
                        n_i = k_inc; n_j = j_inc;
                        n_state = ST_F_U_RP;
                    end else begin
                        factor_next = 1'b1;
                    end
                end
            end
            ST_F_E_RP: begin
                piv_raddr = n_m1[IW-1:0];
                n_state   = ST_F_E_RM;
            end
            ST_F_E_RM: begin
                mat_raddr = {piv_rdata, n_m1[IW-1:0]};
                n_state   = ST_F_E_CHK;
            end
            ST_F_E_CHK: begin
                // zero last diagonal reports the order
                n_sing  = (mat_rdata == '0) ? 7'(n_eff) : r_info;
                n_state = ST_F_FIN;
            end
            ST_F_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{index: '0, result_value: '0, info: r_sing,
                                 status: r_sat, last: 1'b1};
                    n_state  = ST_IDLE;
                end
            end

            // ---- solve ----
            ST_S_BEGIN: begin
                piv_raddr = r_k[IW-1:0];
                n_state   = ST_S_P;
            end
            ST_S_P: begin
                n_pk = piv_rdata;
                if (!r_tmode && !r_back) begin
                    rhs_raddr = piv_rdata;
                end else if (!r_tmode) begin
                    sol_raddr = r_k[IW-1:0];
                end else begin
                    rhs_raddr = r_k[IW-1:0];
                end
                n_state = ST_S_T;
            end
            ST_S_T: begin
                n_t     = (!r_tmode && r_back) ? sol_rdata : rhs_rdata;
                n_j     = r_back ? k_inc : '0;
                n_state = ST_S_CHK;
            end
            ST_S_CHK: begin
                if (r_back ? (r_j < n_eff) : (r_j < r_k)) begin
                    n_state = ST_S_RP;
                end else begin
                    n_state = ST_S_TAIL;
                end
            end
            ST_S_RP: begin
                piv_raddr = r_j[IW-1:0];
                n_state   = ST_S_RD;
            end
            ST_S_RD: begin
                n_pi = piv_rdata;
                if (!r_tmode) begin
                    mat_raddr = {r_pk, r_j[IW-1:0]};
                    sol_raddr = r_j[IW-1:0];
                end else begin
                    mat_raddr = {piv_rdata, r_k[IW-1:0]};
                    if (!r_back) begin
                        rhs_raddr = r_j[IW-1:0];
                    end else begin
                        sol_raddr = piv_rdata;
                    end
                end
                n_state = ST_S_MUL;
            end
            ST_S_MUL: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_MUL;
                alu_req.a     = mat_rdata;
                alu_req.b     = (r_tmode && !r_back) ? rhs_rdata : sol_rdata;
                n_state       = ST_S_WM;
            end
            ST_S_WM: begin
                if (alu_rsp.done) begin
                    alu_req.start = 1'b1;
                    n_state       = ST_S_WS;
                end
            end
            ST_S_WS: begin
                if (alu_rsp.done) begin
                    n_t     = alu_rsp.res;
                    n_j     = j_inc;
                    n_state = ST_S_CHK;
                end
            end
            ST_S_TAIL: begin
                if (need_div) begin
                    mat_raddr = {r_pk, r_k[IW-1:0]};
                    n_state   = ST_S_DIV;
                end else begin
                    sol_we    = 1'b1;
                    sol_waddr = r_tmode ? r_pk : r_k[IW-1:0];
                    sol_wdata = r_t;
                    solve_next = 1'b1;
                end
            end
            ST_S_DIV: begin
                alu_req.start = 1'b1;
                alu_req.op    = ALU_DIV;
                alu_req.a     = r_t;
                alu_req.b     = mat_rdata;
                n_state       = ST_S_DW;
            end
            ST_S_DW: begin
                if (alu_rsp.done) begin
                    // transposed forward overwrites the right-hand side
                    sol_we    = !r_tmode;
                    rhs_we    = r_tmode;
                    sol_waddr = r_k[IW-1:0];
                    rhs_waddr = r_k[IW-1:0];
                    sol_wdata = alu_rsp.res;
                    rhs_wdata = alu_rsp.res;
                    solve_next = 1'b1;
                end
            end
            ST_EM_R: begin
                sol_raddr = r_k[IW-1:0];
                n_state   = ST_EM_W;
            end
            ST_EM_W: begin
                sol_raddr = r_k[IW-1:0];
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{index: 6'(r_k), result_value: sol_rdata,
                                 info: r_sing, status: r_sat,
                                 last: (k_inc == n_eff)};
                    if (k_inc == n_eff) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = k_inc;
                        n_state = ST_EM_R;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // next pivot column
        if (factor_next) begin
            n_k = k_inc;
            if (k_inc2 < n_eff) begin
                n_i = k_inc; n_best = '0; n_found = 1'b0;
                n_state = ST_F_PS_RP;
            end else begin
                n_state = ST_F_E_RP;
            end
        end

        // next row of the triangular sweep
        if (solve_next) begin
            n_state = ST_S_BEGIN;
            if (!r_back) begin
                if (k_inc == n_eff) begin
                    n_back = 1'b1;
                    n_k    = n_m1;
                end else begin
                    n_k = k_inc;
                end
            end else if (r_k == '0) begin
                n_state = ST_EM_R;
            end else begin
                n_k = r_k - ONE_C;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_order  <= 7'd16;
            r_tmode  <= 1'b0;
            r_sing   <= '0;
            r_info   <= '0;
            r_sat    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_order  <= n_order;
            r_tmode  <= n_tmode;
            r_sing   <= n_sing;
            r_info   <= n_info;
            r_sat    <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;   r_i <= n_i;   r_j <= n_j;   r_mi <= n_mi;
        r_pk <= n_pk; r_pi <= n_pi; r_pm <= n_pm;
        r_found <= n_found; r_best <= n_best; r_pv <= n_pv;
        r_t <= n_t;   r_l <= n_l;   r_back <= n_back;
        r_out <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

endmodule

>>> src/luf_checker.sv
// Port-level checks for lu_factor_and_solve, bound to the top level.
// Depends on luf_pkg and lu_factor_and_solve.
`timescale 1ns / 1ps

module luf_checker
    import luf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input t_in_word   i_in_word,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_word  o_out_word,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input t_cfg_reg   i_cfg_index,
    input logic [6:0] i_cfg_data
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_word.func == FN_FACTOR || i_in_word.func == FN_SOLVE))
        |=> !o_in_ready)
        else $error("ready during factor or solve");

    a_load_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_word.func == FN_LOAD_MAT || i_in_word.func == FN_LOAD_RHS))
        |=> (o_out_valid && o_out_word.last && !o_out_word.status &&
             o_out_word.result_value == '0))
        else $error("bad load acknowledgement");

endmodule

bind lu_factor_and_solve luf_checker u_luf_checker (.*);

>>> tb/testbench.sv
// Self-checking bench for lu_factor_and_solve: directed and random load, factor and
// solve traffic, with a predictor in SystemVerilog checking every output word.
// Depends on luf_pkg and the lu_factor_and_solve RTL.
`timescale 1ns / 1ps

module testbench
    import luf_pkg::*;
();

    localparam int NMAX = 16;
    localparam longint QONE = 65536;
    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_word;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_reg   i_cfg_index;
    logic [6:0] i_cfg_data;

    lu_factor_and_solve #(.MAX_ORDER(NMAX)) dut (.*);

    // predictor state
    logic signed [31:0] lu_mat [NMAX*NMAX];
    logic [3:0]         piv [NMAX];
    logic signed [31:0] rhs [NMAX];
    logic signed [31:0] sol [NMAX];
    logic [6:0]         sing_info;
    logic [6:0]         cfg_order;
    logic               cfg_trans;
    logic               sat_seen;

    t_in_word  pending_words [$];
    t_out_word expected_words [$];
    int        errors;
    longint    cycles;
    bit        hold_request;   // asks the sink to stall for a long stretch

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------- fixed-point arithmetic ----------------
    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            return SMAX;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            return SMIN;
        end
        return 32'(v);
    endfunction

    // product rounded to nearest, ties upward
    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint p, q;
        p = longint'(a) * longint'(b) + 32768;
        if (p >= 0) q = p / QONE;
        else q = -((-p + (QONE - 1)) / QONE);
        return clamp32(q);
    endfunction

    function automatic logic signed [31:0] fx_sub(logic signed [31:0] a, logic signed [31:0] b);
        return clamp32(longint'(a) - longint'(b));
    endfunction

    // truncating quotient; zero divisor saturates by sign of dividend
    function automatic logic signed [31:0] fx_div(logic signed [31:0] a, logic signed [31:0] b);
        if (b == 0) begin
            sat_seen = 1'b1;
            return (a < 0) ? SMIN : SMAX;
        end
        return clamp32((longint'(a) * QONE) / longint'(b));
    endfunction

    function automatic int active_order();
        if (cfg_order < 1) return 1;
        if (cfg_order > NMAX) return NMAX;
        return cfg_order;
    endfunction

    // in-place elimination, rows tracked through piv instead of swapped
    task automatic factor_matrix(int n);
        int info, m, pk, pi;
        longint best, mag;
        logic signed [31:0] pivot;
        info = 0;
        for (int k = 0; k < n; k++) piv[k] = 4'(k);
        for (int k = 0; k + 1 < n; k++) begin
            best = 0;
            m = -1;
            for (int i = k; i < n; i++) begin
                mag = lu_mat[piv[i]*NMAX + k];
                if (mag < 0) mag = -mag;
                if (mag > best) begin
                    best = mag;
                    m = i;
                end
            end
            if (m < 0) begin
                info = k + 1;   // all-zero column skipped
                continue;
            end
            pk = piv[m];
            piv[m] = piv[k];
            piv[k] = 4'(pk);
            pivot = lu_mat[pk*NMAX + k];
            for (int i = k + 1; i < n; i++)
                lu_mat[piv[i]*NMAX + k] = fx_div(lu_mat[piv[i]*NMAX + k], pivot);
            for (int j = k + 1; j < n; j++)
                for (int i = k + 1; i < n; i++) begin
                    pi = piv[i];
                    lu_mat[pi*NMAX + j] = fx_sub(lu_mat[pi*NMAX + j],
                        fx_mul(lu_mat[pi*NMAX + k], lu_mat[pk*NMAX + j]));
                end
        end
        if (lu_mat[piv[n-1]*NMAX + n - 1] == 0) info = n;
        sing_info = 7'(info);
    endtask

    task automatic solve_direct(int n);
        logic signed [31:0] t;
        int pk;
        for (int k = 0; k < n; k++) begin
            pk = piv[k];
            t = rhs[pk];
            for (int j = 0; j < k; j++) t = fx_sub(t, fx_mul(lu_mat[pk*NMAX + j], sol[j]));
            sol[k] = t;
        end
        for (int k = n - 1; k >= 0; k--) begin
            pk = piv[k];
            t = sol[k];
            for (int j = k + 1; j < n; j++) t = fx_sub(t, fx_mul(lu_mat[pk*NMAX + j], sol[j]));
            sol[k] = fx_div(t, lu_mat[pk*NMAX + k]);
        end
    endtask

    // transposed system; intermediate vector overwrites rhs
    task automatic solve_transposed(int n);
        logic signed [31:0] t;
        int pi;
        for (int k = 0; k < n; k++) begin
            t = rhs[k];
            for (int i = 0; i < k; i++)
                t = fx_sub(t, fx_mul(lu_mat[piv[i]*NMAX + k], rhs[i]));
            rhs[k] = fx_div(t, lu_mat[piv[k]*NMAX + k]);
        end
        for (int k = n - 1; k >= 0; k--) begin
            t = rhs[k];
            for (int i = k + 1; i < n; i++) begin
                pi = piv[i];
                t = fx_sub(t, fx_mul(lu_mat[pi*NMAX + k], sol[pi]));
            end
            sol[piv[k]] = t;
        end
    endtask

    function automatic t_out_word ack_word(logic st);
        t_out_word w;
        w = '0;
        w.info = sing_info;
        w.status = st;
        w.last = 1'b1;
        return w;
    endfunction

    // predict output words of one accepted input word
    task automatic predict_words(t_in_word w);
        int n;
        t_out_word o;
        n = active_order();
        case (w.func)
            FN_LOAD_MAT: begin
                if (w.row < NMAX && w.col < NMAX) lu_mat[w.row*NMAX + w.col] = w.value;
                expected_words.push_back(ack_word(1'b0));
            end
            FN_LOAD_RHS: begin
                if (w.row < NMAX) rhs[w.row] = w.value;
                expected_words.push_back(ack_word(1'b0));
            end
            FN_FACTOR: begin
                sat_seen = 1'b0;
                factor_matrix(n);
                expected_words.push_back(ack_word(sat_seen));
            end
            default: begin
                sat_seen = 1'b0;
                if (cfg_trans) solve_transposed(n);
                else solve_direct(n);
                for (int k = 0; k < n; k++) begin
                    o.index = 6'(k);
                    o.result_value = sol[k];
                    o.info = sing_info;
                    o.status = sat_seen;
                    o.last = (k == n - 1);
                    expected_words.push_back(o);
                end
            end
        endcase
    endtask

    // ---------------- driver ----------------
    int src_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready) predict_words(i_in_word);
            if (!i_in_valid || o_in_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_in_word <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    src_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                               ($urandom_range(0, 19) == 0 ? $urandom_range(20, 60)
                                                           : $urandom_range(1, 3));
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- long sink stall ----------------
    int hold_left;
    bit hold_used;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_request && !hold_used) begin
            hold_left <= 300;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------- monitor ----------------
    int sink_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected output word %p", o_out_word);
                    errors++;
                end else begin
                    t_out_word e;
                    e = expected_words.pop_front();
                    if (o_out_word.index !== e.index) begin
                        $error("index: exp %0d got %0d", e.index, o_out_word.index);
                        errors++;
                    end
                    if (o_out_word.result_value !== e.result_value) begin
                        $error("result_value: exp %0d got %0d", e.result_value,
                               o_out_word.result_value);
                        errors++;
                    end
                    if (o_out_word.info !== e.info) begin
                        $error("info: exp %0d got %0d", e.info, o_out_word.info);
                        errors++;
                    end
                    if (o_out_word.status !== e.status) begin
                        $error("status: exp %0d got %0d", e.status, o_out_word.status);
                        errors++;
                    end
                    if (o_out_word.last !== e.last) begin
                        $error("last: exp %0d got %0d", e.last, o_out_word.last);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 9) < 3)
                    sink_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50)
                                                             : $urandom_range(1, 3);
            end
        end
    end

    // ---------------- stimulus ----------------
    function automatic t_in_word make_word(t_func f, int r, int c, logic signed [31:0] v);
        t_in_word w;
        w.func = f;
        w.row = 6'(r);
        w.col = 6'(c);
        w.value = v;
        return w;
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return SMAX;
            1: return SMIN;
            2: return 0;
            3, 4: return 32'($urandom);
            default: return $signed(32'($urandom_range(0, 8 * 65536))) - 32'sd262144;
        endcase
    endfunction

    // full matrix, factor, rhs, solve (sometimes twice); optional noise loads mixed in
    task automatic queue_problem(int n, int zero_col, bit noise);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                pending_words.push_back(make_word(FN_LOAD_MAT, r, c,
                    (c == zero_col) ? 32'sd0 : rand_value()));
                if (noise && $urandom_range(0, 7) == 0)
                    pending_words.push_back(make_word(FN_LOAD_MAT,
                        $urandom_range(NMAX, 63), $urandom_range(0, 63), 32'($urandom)));
            end
        pending_words.push_back(make_word(FN_FACTOR, $urandom_range(0, 63),
                                          $urandom_range(0, 63), 32'($urandom)));
        for (int r = 0; r < n; r++)
            pending_words.push_back(make_word(FN_LOAD_RHS, r, $urandom_range(0, 63),
                                              rand_value()));
        if (noise)
            pending_words.push_back(make_word(FN_LOAD_RHS, $urandom_range(NMAX, 63), 0,
                                              32'($urandom)));
        pending_words.push_back(make_word(FN_SOLVE, $urandom_range(0, 63),
                                          $urandom_range(0, 63), 32'($urandom)));
        if ($urandom_range(0, 1))
            pending_words.push_back(make_word(FN_SOLVE, 0, 0, 0));
    endtask

    // sampled at the falling edge, after every clocked update has settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0);
    endtask

    // config write only while the block is idle
    task automatic write_reg(t_cfg_reg idx, logic [6:0] data);
        wait_idle();
        repeat (20) @(posedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ORDER) cfg_order = data;
        else cfg_trans = data[0];
    endtask

    initial begin
        int n;
        errors = 0;
        cycles = 0;
        hold_request = 0;
        sing_info = '0;
        cfg_order = 7'd16;
        cfg_trans = 1'b0;
        foreach (lu_mat[i]) lu_mat[i] = '0;
        foreach (piv[i]) begin
            piv[i] = '0;
            rhs[i] = '0;
            sol[i] = '0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ORDER;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: order 0 (used as 1), extremes, singular 2x2
        write_reg(CFG_ORDER, 7'd0);
        pending_words.push_back(make_word(FN_LOAD_MAT, 0, 0, SMAX));
        pending_words.push_back(make_word(FN_LOAD_MAT, 63, 63, SMIN));
        pending_words.push_back(make_word(FN_FACTOR, 0, 0, 0));
        pending_words.push_back(make_word(FN_LOAD_RHS, 0, 63, SMIN));
        pending_words.push_back(make_word(FN_LOAD_RHS, 63, 0, SMAX));
        pending_words.push_back(make_word(FN_SOLVE, 0, 0, 0));
        write_reg(CFG_ORDER, 7'd2);
        write_reg(CFG_TRANSPOSE, 7'd1);
        pending_words.push_back(make_word(FN_LOAD_MAT, 0, 0, 0));
        pending_words.push_back(make_word(FN_LOAD_MAT, 0, 1, 32'sh0001_0000));
        pending_words.push_back(make_word(FN_LOAD_MAT, 1, 0, 0));
        pending_words.push_back(make_word(FN_LOAD_MAT, 1, 1, 32'sh0002_0000));
        pending_words.push_back(make_word(FN_FACTOR, 0, 0, 0));
        pending_words.push_back(make_word(FN_LOAD_RHS, 0, 0, 32'sh0003_0000));
        pending_words.push_back(make_word(FN_LOAD_RHS, 1, 0, -32'sh0001_0000));
        pending_words.push_back(make_word(FN_SOLVE, 0, 0, 0));
        write_reg(CFG_ORDER, 7'd127);   // above range, used as the built size
        queue_problem(NMAX, -1, 0);
        hold_request = 1;
        write_reg(CFG_TRANSPOSE, 7'd0);
        hold_request = 0;

        // random problems of small order
        for (int p = 0; p < 10; p++) begin
            n = $urandom_range(1, 5);
            write_reg(CFG_ORDER, 7'(n));
            write_reg(CFG_TRANSPOSE, 7'($urandom_range(0, 1)));
            queue_problem(n, ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1, 1);
        end
        wait_idle();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> lu_factor_and_solve.f
src/luf_pkg.sv
src/luf_ram.sv
src/luf_alu.sv
src/lu_factor_and_solve.sv
src/luf_checker.sv
tb/testbench.sv
